FILE: src/vv_pkg.sv
// Shared types and fixed-point helpers for the velocity Verlet atom update.
// Holds the lane result struct, register indexes and the rounding and clipping functions.
// Depends on nothing; used by vv_lane, vv_outq and velocity_verlet_atom_update.
package vv_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_TIME_STEP   = 3'd0;
    localparam logic [2:0] REG_PREFACTOR_0 = 3'd1;
    localparam logic [2:0] REG_PREFACTOR_3 = 3'd4;

    // Reset values, unsigned Q8.24.
    localparam logic [31:0] TIME_STEP_RESET = 32'd83886;
    localparam logic [31:0] PREFACTOR_RESET = 32'd41943;

    // Number of prefactor registers.
    localparam int unsigned NUM_PREFACTORS = 4;

    // Kind codes.
    localparam logic KIND_KICK_DRIFT = 1'b0;
    localparam logic KIND_KICK_ONLY  = 1'b1;

    // Half an LSB of a Q8.24 product, added before the shift.
    localparam logic signed [64:0] ROUND_HALF = 65'sd8388608;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // A 32-bit value together with its clip flag.
    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } t_clip;

    // Result of one axis lane.
    typedef struct packed {
        logic [31:0] new_vel;
        logic [31:0] new_pos;
        logic        sat;
    } t_lane_out;

    // Round half up, shift right by 24 with floor semantics, clip to 32 bits.
    function automatic t_clip round_q24(input logic signed [63:0] prod);
        logic signed [64:0] sum;
        logic signed [40:0] q;
        t_clip              res;
        sum = {prod[63], prod} + ROUND_HALF;
        q   = sum[64:24];
        res.sat   = (q[40:31] != {10{q[31]}});
        res.value = res.sat ? (q[40] ? SAT_MIN : SAT_MAX) : q[31:0];
        return res;
    endfunction

    // Exact sum of two signed 32-bit values, clipped to 32 bits.
    function automatic t_clip add_clip(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        t_clip       res;
        sum = {a[31], a} + {b[31], b};
        res.sat   = (sum[32] != sum[31]);
        res.value = res.sat ? (sum[32] ? SAT_MIN : SAT_MAX) : sum[31:0];
        return res;
    endfunction

endpackage

FILE: src/velocity_verlet_atom_update.sv
// Top level of the velocity Verlet atom update: configuration registers, three axis
// lanes and the merging output queue. Depends on vv_pkg, vv_lane and vv_outq.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: type, force, vel, pos; tuser: kind
// m_axis    out  m_axis_tvalid/tready        tdata: new vel, new pos; tuser: saturated
// cfg       in   i_cfg_we (no wait)          i_cfg_addr, i_cfg_data
//
// One atom is accepted every cycle while fewer than eight transactions are in flight.
// A result passes the four lane stages and is then merged into the queue.
// The queue holds eight results; since the in-flight count includes transactions still
// in the lanes, an output stall holds input back once eight are in flight.
// Reset is synchronous: control state clears and registers return to their defaults.
module velocity_verlet_atom_update #(
    parameter int unsigned NUM_TYPES = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input stream.
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [1:0] atom_type, [33:2] force_x, [65:34] force_y, [97:66] force_z,
    // [129:98] vel_x, [161:130] vel_y, [193:162] vel_z,
    // [225:194] pos_x, [257:226] pos_y, [289:258] pos_z, [295:290] zero
    input  logic [295:0]  s_axis_tdata,
    // [0] kind
    input  logic          s_axis_tuser,
    // Output stream.
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [31:0] new_vel_x, [63:32] new_vel_y, [95:64] new_vel_z,
    // [127:96] new_pos_x, [159:128] new_pos_y, [191:160] new_pos_z
    output logic [191:0]  m_axis_tdata,
    // [0] saturated
    output logic          m_axis_tuser,
    // Configuration write port.
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_data
);

    localparam int unsigned LANE_STAGES = 4;
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned CW          = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers.
    logic [31:0] r_time_step;
    logic [31:0] r_prefactor [vv_pkg::NUM_PREFACTORS];
    logic [1:0]  w_pref_idx;

    assign w_pref_idx = 2'(i_cfg_addr - vv_pkg::REG_PREFACTOR_0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= vv_pkg::TIME_STEP_RESET;
            for (int i = 0; i < vv_pkg::NUM_PREFACTORS; i++) begin
                r_prefactor[i] <= vv_pkg::PREFACTOR_RESET;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr == vv_pkg::REG_TIME_STEP) begin
                r_time_step <= i_cfg_data;
            end else if (i_cfg_addr >= vv_pkg::REG_PREFACTOR_0 &&
                         i_cfg_addr <= vv_pkg::REG_PREFACTOR_3) begin
                r_prefactor[w_pref_idx] <= i_cfg_data;
            end
        end
    end

    // Prefactor selection; types without a register get a zero prefactor.
    logic [1:0]  w_type;
    logic [31:0] w_prefactor;

    assign w_type      = s_axis_tdata[1:0];
    assign w_prefactor = (32'(w_type) < NUM_TYPES) ? r_prefactor[w_type] : '0;

    // Input acceptance and in-flight tracking.
    logic          w_in_acc;
    logic          w_out_acc;
    logic [CW-1:0] r_inflight;

    assign s_axis_tready = (r_inflight < CW'(QUEUE_DEPTH));
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({w_in_acc, w_out_acc})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    // Valid bits that follow the lane stages.
    logic [LANE_STAGES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LANE_STAGES-2:0], w_in_acc};
        end
    end

    // Axis lanes.
    vv_pkg::t_lane_out w_lane_x;
    vv_pkg::t_lane_out w_lane_y;
    vv_pkg::t_lane_out w_lane_z;

    vv_lane u_lane_x (
        .i_clk       (i_clk),
        .i_kind      (s_axis_tuser),
        .i_force     (s_axis_tdata[33:2]),
        .i_vel       (s_axis_tdata[129:98]),
        .i_pos       (s_axis_tdata[225:194]),
        .i_prefactor (w_prefactor),
        .i_time_step (r_time_step),
        .o_res       (w_lane_x)
    );

    vv_lane u_lane_y (
        .i_clk       (i_clk),
        .i_kind      (s_axis_tuser),
        .i_force     (s_axis_tdata[65:34]),
        .i_vel       (s_axis_tdata[161:130]),
        .i_pos       (s_axis_tdata[257:226]),
        .i_prefactor (w_prefactor),
        .i_time_step (r_time_step),
        .o_res       (w_lane_y)
    );

    vv_lane u_lane_z (
        .i_clk       (i_clk),
        .i_kind      (s_axis_tuser),
        .i_force     (s_axis_tdata[97:66]),
        .i_vel       (s_axis_tdata[193:162]),
        .i_pos       (s_axis_tdata[289:258]),
        .i_prefactor (w_prefactor),
        .i_time_step (r_time_step),
        .o_res       (w_lane_z)
    );

    // Merge and output queue.
    vv_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_vld[LANE_STAGES-1]),
        .i_lane_x (w_lane_x),
        .i_lane_y (w_lane_y),
        .i_lane_z (w_lane_z),
        .i_pop    (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata),
        .o_sat    (m_axis_tuser)
    );

    // Assertions.

    // The in-flight count never exceeds the queue depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CW'(QUEUE_DEPTH))
        else $error("in-flight count above queue depth");

    // A pending result implies at least one transaction in flight.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_inflight != '0))
        else $error("output valid with nothing in flight");

    // An accepted input reaches the queue after the lane stages.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> ##(LANE_STAGES - 1) r_vld[LANE_STAGES-1])
        else $error("lane valid bit lost");

    // With nothing in flight, the lanes hold no valid transaction.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> (r_vld == '0))
        else $error("lane valid without in-flight transaction");

endmodule

FILE: src/vv_lane.sv
// One axis lane: half kick v' = v + f*p, then drift x' = x + v'*dt for the first half.
// Four register stages, one multiplier each in stages one and three.
// Depends on vv_pkg.
module vv_lane (
    input  logic                   i_clk,
    input  logic                   i_kind,
    input  logic [31:0]            i_force,
    input  logic [31:0]            i_vel,
    input  logic [31:0]            i_pos,
    input  logic [31:0]            i_prefactor,
    input  logic [31:0]            i_time_step,
    output vv_pkg::t_lane_out      o_res
);

    // Stage 1: force times prefactor.
    logic signed [31:0] w_force;
    logic signed [32:0] w_pref;
    logic signed [64:0] w_kick_prod;
    logic [63:0]        r_kick_prod;
    logic [31:0]        r_vel1;
    logic [31:0]        r_pos1;
    logic               r_kind1;

    assign w_force     = i_force;
    assign w_pref      = {1'b0, i_prefactor};
    assign w_kick_prod = w_force * w_pref;

    always_ff @(posedge i_clk) begin
        r_kick_prod <= w_kick_prod[63:0];
        r_vel1      <= i_vel;
        r_pos1      <= i_pos;
        r_kind1     <= i_kind;
    end

    // Stage 2: round the kick and add it to the velocity.
    vv_pkg::t_clip w_dv;
    vv_pkg::t_clip w_nv;
    logic [31:0]   r_nv2;
    logic [31:0]   r_pos2;
    logic          r_kind2;
    logic          r_sat2;

    assign w_dv = vv_pkg::round_q24(r_kick_prod);
    assign w_nv = vv_pkg::add_clip(r_vel1, w_dv.value);

    always_ff @(posedge i_clk) begin
        r_nv2   <= w_nv.value;
        r_pos2  <= r_pos1;
        r_kind2 <= r_kind1;
        r_sat2  <= w_dv.sat | w_nv.sat;
    end

    // Stage 3: new velocity times the timestep.
    logic signed [31:0] w_nv_s;
    logic signed [32:0] w_dt;
    logic signed [64:0] w_drift_prod;
    logic [63:0]        r_drift_prod;
    logic [31:0]        r_nv3;
    logic [31:0]        r_pos3;
    logic               r_kind3;
    logic               r_sat3;

    assign w_nv_s       = r_nv2;
    assign w_dt         = {1'b0, i_time_step};
    assign w_drift_prod = w_nv_s * w_dt;

    always_ff @(posedge i_clk) begin
        r_drift_prod <= w_drift_prod[63:0];
        r_nv3        <= r_nv2;
        r_pos3       <= r_pos2;
        r_kind3      <= r_kind2;
        r_sat3       <= r_sat2;
    end

    // Stage 4: round the drift and add it to the position; the second half passes it through.
    vv_pkg::t_clip     w_dx;
    vv_pkg::t_clip     w_nx;
    vv_pkg::t_lane_out r_res;

    assign w_dx = vv_pkg::round_q24(r_drift_prod);
    assign w_nx = vv_pkg::add_clip(r_pos3, w_dx.value);

    always_ff @(posedge i_clk) begin
        r_res.new_vel <= r_nv3;
        if (r_kind3 == vv_pkg::KIND_KICK_DRIFT) begin
            r_res.new_pos <= w_nx.value;
            r_res.sat     <= r_sat3 | w_dx.sat | w_nx.sat;
        end else begin
            r_res.new_pos <= r_pos3;
            r_res.sat     <= r_sat3;
        end
    end

    assign o_res = r_res;

endmodule

FILE: src/vv_outq.sv
// Output queue that merges the three lane results into one result transaction.
// A small register FIFO decouples the lanes from the output handshake.
// Depends on vv_pkg.
module vv_outq #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vv_pkg::t_lane_out   i_lane_x,
    input  vv_pkg::t_lane_out   i_lane_y,
    input  vv_pkg::t_lane_out   i_lane_z,
    input  logic                i_pop,
    output logic                o_valid,
    output logic [191:0]        o_data,
    output logic                o_sat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned EW = 193;

    logic [EW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic [EW-1:0] w_entry;

    // Merge: pack the lane values and OR the clip flags.
    assign w_entry = {i_lane_x.sat | i_lane_y.sat | i_lane_z.sat,
                      i_lane_z.new_pos, i_lane_y.new_pos, i_lane_x.new_pos,
                      i_lane_z.new_vel, i_lane_y.new_vel, i_lane_x.new_vel};

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop && o_valid})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr][191:0];
    assign o_sat   = r_mem[r_rd_ptr][192];

endmodule
